// File: rtl/mtf_pkg.sv
package mtf_pkg;

  localparam int CfgW      = 11;
  localparam int ThrW      = 16;
  localparam int PixInW    = 16;
  localparam int RowW      = 11;
  localparam int OutPosW   = 20;
  localparam int TotalW    = 21;
  localparam int MaxHeight = 1024;
  localparam int MinDim    = 3;

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = QPtrW + 1;

  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  localparam logic [1:0] RegFrameWidth  = 2'd0;
  localparam logic [1:0] RegFrameHeight = 2'd1;
  localparam logic [1:0] RegThreshold   = 2'd2;
  localparam logic [1:0] RegMaxValue    = 2'd3;

  typedef enum logic {
    OpPixel = 1'b0,
    OpDrain = 1'b1
  } op_e;

  typedef struct packed {
    logic is_pix;
    logic emit;
    logic interior;
    logic last;
  } mtf_ctl_t;

  typedef struct packed {
    logic [CfgW-1:0]   w_eff;
    logic [CfgW-1:0]   h_eff;
    logic [TotalW-1:0] total;
    logic [ThrW-1:0]   threshold;
    logic [ThrW-1:0]   max_value;
  } mtf_cfg_t;

endpackage

// File: rtl/mtf_queue.sv
module mtf_queue #(
  parameter int DataW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output logic             valid_o,
  output logic             full_o
);
  import mtf_pkg::*;

  logic [DataW-1:0] mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  assign data_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == QCntW'(QueueDepth));

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/mtf_front.sv
module mtf_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic [mtf_pkg::PixInW-1:0]     pixel_i,
  input  mtf_pkg::mtf_cfg_t              cfg_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output mtf_pkg::mtf_ctl_t              ctl_o,
  output logic [$clog2(MAX_WIDTH)-1:0]   col_o,
  output logic [mtf_pkg::PixInW-1:0]     px_o
);
  import mtf_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int CntW = (ColW + 1 > CfgW) ? ColW + 1 : CfgW;

  logic [ColW-1:0]    in_col_q, in_col_d;
  logic [RowW-1:0]    in_row_q, in_row_d;
  logic [OutPosW-1:0] out_pos_q, out_pos_d;
  logic               done_q, done_d;

  logic [CntW-1:0]   col_inc;
  logic              col_wrap;
  logic [RowW-1:0]   row_inc;
  logic [TotalW-1:0] pos_inc;
  logic              drain_last;
  logic              is_drain;
  logic              accept;
  logic              emit;
  logic              interior;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign col_o      = in_col_q;
  assign px_o       = pixel_i;

  always_comb begin
    col_inc    = CntW'(in_col_q) + CntW'(1);
    col_wrap   = (col_inc >= CntW'(cfg_i.w_eff));
    row_inc    = in_row_q + RowW'(1);
    pos_inc    = TotalW'(out_pos_q) + TotalW'(1);
    drain_last = (pos_inc >= cfg_i.total);
    is_drain   = (operation_i == OpDrain);
    emit       = (in_row_q >= RowW'(2)) || ((in_row_q == RowW'(1)) && (in_col_q >= ColW'(1)));
    interior   = (in_row_q >= RowW'(2)) && (in_col_q >= ColW'(2));
    push_o     = accept && (is_drain ? done_q : !done_q);

    ctl_o.is_pix   = !is_drain;
    ctl_o.emit     = is_drain || emit;
    ctl_o.interior = !is_drain && interior;
    ctl_o.last     = is_drain && drain_last;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_pos_d = out_pos_q;
    done_d    = done_q;

    if (push_o) begin
      if (is_drain) begin
        if (drain_last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_pos_d = '0;
          done_d    = 1'b0;
        end else begin
          out_pos_d = out_pos_q + OutPosW'(1);
        end
      end else begin
        if (emit) begin
          out_pos_d = out_pos_q + OutPosW'(1);
        end
        if (col_wrap) begin
          in_col_d = '0;
          in_row_d = row_inc;
          if (row_inc >= cfg_i.h_eff) begin
            done_d = 1'b1;
          end
        end else begin
          in_col_d = col_inc[ColW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_pos_q <= '0;
      done_q    <= 1'b0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_pos_q <= out_pos_d;
      done_q    <= done_d;
    end
  end

endmodule

// File: rtl/mtf_back.sv
module mtf_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  mtf_pkg::mtf_ctl_t            q_ctl_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col_i,
  input  logic [mtf_pkg::PixInW-1:0]   q_px_i,
  output logic                         q_pop_o,
  input  mtf_pkg::mtf_cfg_t            cfg_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mtf_pkg::ThrW-1:0]     binary_pixel_o,
  output logic                         frame_last_o
);
  import mtf_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int PixW = PIXEL_BITS;
  localparam int CmpW = (PixW > ThrW) ? PixW : ThrW;

  function automatic logic [PixW-1:0] min2(input logic [PixW-1:0] a, input logic [PixW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PixW-1:0] max2(input logic [PixW-1:0] a, input logic [PixW-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [PixW-1:0] med3(input logic [PixW-1:0] a, input logic [PixW-1:0] b,
                                           input logic [PixW-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // line stores: {upper, middle} per column
  logic [2*PixW-1:0] lines_mem [MAX_WIDTH];
  logic [2*PixW-1:0] rd_q;
  logic [PixW-1:0]   rd_up, rd_mid;

  logic advance;
  logic line_wr;

  logic            s1_valid_q;
  mtf_ctl_t        s1_ctl_q;
  logic [ColW-1:0] s1_col_q;
  logic [PixW-1:0] s1_px_q;

  logic [PixW-1:0] win_q [9];

  logic     w_valid_q, p1_valid_q, p2_valid_q, p3_valid_q;
  mtf_ctl_t w_ctl_q, p1_ctl_q, p2_ctl_q, p3_ctl_q;

  logic [PixW-1:0] p1_lo_q [3];
  logic [PixW-1:0] p1_md_q [3];
  logic [PixW-1:0] p1_hi_q [3];
  logic [PixW-1:0] p2_lo_q, p2_md_q, p2_hi_q;
  logic [PixW-1:0] p3_med_q;

  logic            out_valid_q;
  logic [ThrW-1:0] out_pix_q;
  logic            out_last_q;
  logic            above;

  assign advance = !out_valid_q || out_ready_i;
  assign q_pop_o = advance && q_valid_i;
  assign line_wr = advance && s1_valid_q && s1_ctl_q.is_pix;
  assign rd_up   = rd_q[2*PixW-1:PixW];
  assign rd_mid  = rd_q[PixW-1:0];
  assign above   = CmpW'(p3_med_q) > CmpW'(cfg_i.threshold);

  assign out_valid_o    = out_valid_q;
  assign binary_pixel_o = out_pix_q;
  assign frame_last_o   = out_last_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rd_q <= lines_mem[q_col_i];
    end
    if (line_wr) begin
      lines_mem[s1_col_q] <= {rd_mid, s1_px_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      w_valid_q   <= 1'b0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      p3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= q_valid_i;
      w_valid_q   <= s1_valid_q;
      p1_valid_q  <= w_valid_q;
      p2_valid_q  <= p1_valid_q;
      p3_valid_q  <= p2_valid_q;
      out_valid_q <= p3_valid_q && p3_ctl_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (q_valid_i) begin
        s1_ctl_q <= q_ctl_i;
        s1_col_q <= q_col_i;
        s1_px_q  <= PixW'(q_px_i);
      end
      if (s1_valid_q && s1_ctl_q.is_pix) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= rd_up;
        win_q[3] <= win_q[4];
        win_q[4] <= win_q[5];
        win_q[5] <= rd_mid;
        win_q[6] <= win_q[7];
        win_q[7] <= win_q[8];
        win_q[8] <= s1_px_q;
      end
      w_ctl_q <= s1_ctl_q;

      // sort each window row
      p1_ctl_q <= w_ctl_q;
      for (int r = 0; r < 3; r++) begin
        p1_lo_q[r] <= min2(min2(win_q[3*r], win_q[3*r+1]), win_q[3*r+2]);
        p1_md_q[r] <= med3(win_q[3*r], win_q[3*r+1], win_q[3*r+2]);
        p1_hi_q[r] <= max2(max2(win_q[3*r], win_q[3*r+1]), win_q[3*r+2]);
      end

      p2_ctl_q <= p1_ctl_q;
      p2_lo_q  <= max2(max2(p1_lo_q[0], p1_lo_q[1]), p1_lo_q[2]);
      p2_md_q  <= med3(p1_md_q[0], p1_md_q[1], p1_md_q[2]);
      p2_hi_q  <= min2(min2(p1_hi_q[0], p1_hi_q[1]), p1_hi_q[2]);

      p3_ctl_q <= p2_ctl_q;
      p3_med_q <= med3(p2_lo_q, p2_md_q, p2_hi_q);

      out_pix_q  <= (p3_ctl_q.interior && above) ? cfg_i.max_value : '0;
      out_last_q <= p3_ctl_q.last;
    end
  end

endmodule

// File: rtl/median3x3_threshold_filter.sv
// Channel   Handshake                    Payload
// in        in_valid_i / in_ready_o      operation_i, pixel_i
// out       out_valid_o / out_ready_i    binary_pixel_o, frame_last_o
// cfg       psel, penable, pwrite        paddr, pwdata -> prdata (pready tied high)
//
// One item per clock while the output is not stalled. A result passes, in order, through the
// queue, line store read, window shift, three median compare stages, threshold register.
// A 4-entry queue sits between the counters and the filter pipeline; in_ready_o falls
// only when it is full.
// Reset clears counters and valid bits; line stores are not cleared, no init pass.
module median3x3_threshold_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic [mtf_pkg::PixInW-1:0]     pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mtf_pkg::ThrW-1:0]       binary_pixel_o,
  output logic                           frame_last_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mtf_pkg::ApbAddrW-1:0]   paddr,
  input  logic [mtf_pkg::ApbDataW-1:0]   pwdata,
  output logic [mtf_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);
  import mtf_pkg::*;

  localparam int ColW     = $clog2(MAX_WIDTH);
  localparam int QDataW   = $bits(mtf_ctl_t) + ColW + PixInW;
  localparam int RstWEff  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int RstTotal = RstWEff * 1024;

  logic [CfgW-1:0]   frame_width_q, frame_width_d;
  logic [CfgW-1:0]   frame_height_q, frame_height_d;
  logic [ThrW-1:0]   threshold_q, threshold_d;
  logic [ThrW-1:0]   max_value_q, max_value_d;
  logic [CfgW-1:0]   w_eff_q, w_eff_d;
  logic [CfgW-1:0]   h_eff_q, h_eff_d;
  logic [TotalW-1:0] total_q, total_d;

  logic            cfg_wr;
  logic [1:0]      reg_idx;
  logic [CfgW-1:0] dim_new;
  logic [CfgW-1:0] w_clamp, h_clamp;
  mtf_cfg_t        cfg;

  logic              q_push, q_pop, q_valid, q_full;
  mtf_ctl_t          f_ctl, b_ctl;
  logic [ColW-1:0]   f_col, b_col;
  logic [PixInW-1:0] f_px, b_px;
  logic [QDataW-1:0] q_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign dim_new = pwdata[CfgW-1:0];

  always_comb begin
    if (dim_new < CfgW'(MinDim)) begin
      w_clamp = CfgW'(MinDim);
    end else if (32'(dim_new) > MAX_WIDTH) begin
      w_clamp = CfgW'(MAX_WIDTH);
    end else begin
      w_clamp = dim_new;
    end
    if (dim_new < CfgW'(MinDim)) begin
      h_clamp = CfgW'(MinDim);
    end else if (dim_new > CfgW'(MaxHeight)) begin
      h_clamp = CfgW'(MaxHeight);
    end else begin
      h_clamp = dim_new;
    end

    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    threshold_d    = threshold_q;
    max_value_d    = max_value_q;
    w_eff_d        = w_eff_q;
    h_eff_d        = h_eff_q;
    total_d        = total_q;

    if (cfg_wr) begin
      unique case (reg_idx)
        RegFrameWidth: begin
          frame_width_d = dim_new;
          w_eff_d       = w_clamp;
          total_d       = TotalW'(w_clamp) * TotalW'(h_eff_q);
        end
        RegFrameHeight: begin
          frame_height_d = dim_new;
          h_eff_d        = h_clamp;
          total_d        = TotalW'(w_eff_q) * TotalW'(h_clamp);
        end
        RegThreshold: threshold_d = pwdata[ThrW-1:0];
        RegMaxValue:  max_value_d = pwdata[ThrW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CfgW'(1024);
      frame_height_q <= CfgW'(1024);
      threshold_q    <= ThrW'(127);
      max_value_q    <= ThrW'(255);
      w_eff_q        <= CfgW'(RstWEff);
      h_eff_q        <= CfgW'(1024);
      total_q        <= TotalW'(RstTotal);
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      threshold_q    <= threshold_d;
      max_value_q    <= max_value_d;
      w_eff_q        <= w_eff_d;
      h_eff_q        <= h_eff_d;
      total_q        <= total_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegFrameWidth:  prdata = ApbDataW'(frame_width_q);
      RegFrameHeight: prdata = ApbDataW'(frame_height_q);
      RegThreshold:   prdata = ApbDataW'(threshold_q);
      RegMaxValue:    prdata = ApbDataW'(max_value_q);
    endcase
  end

  assign cfg.w_eff     = w_eff_q;
  assign cfg.h_eff     = h_eff_q;
  assign cfg.total     = total_q;
  assign cfg.threshold = threshold_q;
  assign cfg.max_value = max_value_q;

  mtf_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .pixel_i    (pixel_i),
    .cfg_i      (cfg),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .ctl_o      (f_ctl),
    .col_o      (f_col),
    .px_o       (f_px)
  );

  mtf_queue #(
    .DataW(QDataW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i ({f_ctl, f_col, f_px}),
    .pop_i  (q_pop),
    .data_o (q_out),
    .valid_o(q_valid),
    .full_o (q_full)
  );

  assign {b_ctl, b_col, b_px} = q_out;

  mtf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_ctl_i       (b_ctl),
    .q_col_i       (b_col),
    .q_px_i        (b_px),
    .q_pop_o       (q_pop),
    .cfg_i         (cfg),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .binary_pixel_o(binary_pixel_o),
    .frame_last_o  (frame_last_o)
  );

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("push into full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_total_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (total_q == TotalW'(w_eff_q) * TotalW'(h_eff_q)) && (w_eff_q >= CfgW'(MinDim))
               && (h_eff_q >= CfgW'(MinDim)))
    else $error("frame size out of step with dimensions");

  a_last_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> binary_pixel_o == '0)
    else $error("frame_last item carries nonzero pixel");

endmodule

// File: bench/mtf_binary_checker.sv
`timescale 1ns / 100ps
module mtf_binary_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pix_valid_i,
  input  logic                         pix_ready_i,
  input  logic                         op_i,
  input  logic [mtf_pkg::PixInW-1:0]   pix_i,
  input  logic                         res_valid_i,
  input  logic                         res_ready_i,
  input  logic [mtf_pkg::ThrW-1:0]     res_value_i,
  input  logic                         res_last_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [mtf_pkg::ApbAddrW-1:0] paddr_i,
  input  logic [mtf_pkg::ApbDataW-1:0] pwdata_i,
  output int                           errors_o,
  output int                           pending_o
);
  import mtf_pkg::*;

  localparam int LineLen = 1024;
  localparam int WinTaps = 9;

  typedef struct packed {
    logic [ThrW-1:0] level;
    logic            last;
  } bin_px_t;

  bit [CfgW-1:0]    width_reg;
  bit [CfgW-1:0]    height_reg;
  bit [ThrW-1:0]    thr_reg;
  bit [ThrW-1:0]    max_reg;
  bit [PixInW-1:0]  upper_line [LineLen];
  bit [PixInW-1:0]  middle_line [LineLen];
  bit [PixInW-1:0]  win [WinTaps];
  int               col;
  int               row;
  bit [OutPosW-1:0] out_pos;
  bit               frame_fed;
  bin_px_t          awaited_px [$];
  bin_px_t          seen;
  int               errors;

  function automatic int fit_dim(input int v, input int hi);
    return (v < MinDim) ? MinDim : ((v > hi) ? hi : v);
  endfunction

  function automatic bit [PixInW-1:0] window_median();
    int              below;
    int              upto;
    bit [PixInW-1:0] m;
    m = '0;
    for (int i = 0; i < WinTaps; i++) begin
      below = 0;
      upto  = 0;
      for (int j = 0; j < WinTaps; j++) begin
        if (win[j] < win[i]) below++;
        if (win[j] <= win[i]) upto++;
      end
      if (below <= WinTaps / 2 && upto > WinTaps / 2) m = win[i];
    end
    return m;
  endfunction

  task automatic filter_item(input op_e op, input bit [PixInW-1:0] px);
    int      w;
    int      h;
    int      total;
    int      c;
    bin_px_t r;
    w     = fit_dim(width_reg, LineLen);
    h     = fit_dim(height_reg, MaxHeight);
    total = w * h;
    r     = '0;
    if (op == OpDrain) begin
      if (frame_fed) begin
        r.last = (int'(out_pos) + 1 >= total);
        awaited_px.push_back(r);
        if (r.last) begin
          col       = 0;
          row       = 0;
          out_pos   = '0;
          frame_fed = 1'b0;
        end else begin
          out_pos = out_pos + 1'b1;
        end
      end
    end else if (!frame_fed) begin
      c = (col < LineLen) ? col : 0;
      for (int k = 0; k < WinTaps; k += 3) begin
        win[k]   = win[k+1];
        win[k+1] = win[k+2];
      end
      win[2] = upper_line[c];
      win[5] = middle_line[c];
      win[8] = px;
      upper_line[c]  = middle_line[c];
      middle_line[c] = px;
      if (row >= 2 || (row == 1 && col >= 1)) begin
        // borders always come out as zero
        if (row >= 2 && col >= 2 && window_median() > thr_reg) r.level = max_reg;
        awaited_px.push_back(r);
        out_pos = out_pos + 1'b1;
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) frame_fed = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      width_reg  = 11'd1024;
      height_reg = 11'd1024;
      thr_reg    = 16'd127;
      max_reg    = 16'd255;
      win        = '{default: '0};
      col        = 0;
      row        = 0;
      out_pos    = '0;
      frame_fed  = 1'b0;
      errors     = 0;
      awaited_px.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          RegFrameWidth:  width_reg  = pwdata_i[CfgW-1:0];
          RegFrameHeight: height_reg = pwdata_i[CfgW-1:0];
          RegThreshold:   thr_reg    = pwdata_i[ThrW-1:0];
          RegMaxValue:    max_reg    = pwdata_i[ThrW-1:0];
          default: ;
        endcase
      end
      if (pix_valid_i && pix_ready_i) filter_item(op_e'(op_i), pix_i);
      if (res_valid_i && res_ready_i) begin
        if (awaited_px.size() == 0) begin
          errors++;
          $display("%0t: binary_pixel_o expected none, got %0d (frame_last_o %b)",
                   $time, res_value_i, res_last_i);
        end else begin
          seen = awaited_px.pop_front();
          if (res_value_i !== seen.level) begin
            errors++;
            $display("%0t: binary_pixel_o expected %0d, got %0d",
                     $time, seen.level, res_value_i);
          end
          if (res_last_i !== seen.last) begin
            errors++;
            $display("%0t: frame_last_o expected %b, got %b", $time, seen.last, res_last_i);
          end
        end
      end
    end
    errors_o  <= errors;
    pending_o <= awaited_px.size();
  end

endmodule

// File: bench/median3x3_threshold_filter_tb.sv
`timescale 1ns / 100ps
module median3x3_threshold_filter_tb;
  import mtf_pkg::*;

  localparam int RandomItems  = 750;
  localparam int QuietFrom    = 620;
  localparam int LongHold     = 300;
  localparam int SettleCycles = 12;
  localparam int CycleLimit   = 1_200_000;
  localparam int LineLen      = 1024;
  // whole-frame median is exactly 100
  localparam logic [16*9-1:0] SeedFrame = {16'd65535, 16'd100, 16'd0, 16'd65535, 16'd100,
                                           16'd101, 16'd100, 16'd65535, 16'd0};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                operation_i = 1'b0;
  logic [PixInW-1:0]   pixel_i     = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [ThrW-1:0]     binary_pixel_o;
  logic                frame_last_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ApbAddrW-1:0] paddr       = '0;
  logic [ApbDataW-1:0] pwdata      = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int errors;
  int pending;
  int cycles = 0;
  bit calm = 1'b0;
  bit phase_quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int frame_w;
  int frame_h;
  int frame_rows;
  int fed = 0;
  int items_fed = 0;
  int thr_now;
  int px_mode = 0;

  median3x3_threshold_filter dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .operation_i, .pixel_i,
    .out_valid_o, .out_ready_i, .binary_pixel_o, .frame_last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mtf_binary_checker judge (
    .clk_i, .rst_ni,
    .pix_valid_i (in_valid_i),
    .pix_ready_i (in_ready_o),
    .op_i        (operation_i),
    .pix_i       (pixel_i),
    .res_valid_i (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_value_i (binary_pixel_o),
    .res_last_i  (frame_last_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending);
      $display("** median3x3_threshold_filter: FAILED **");
      $finish;
    end
  end

  function automatic int fit(input int v, input int hi);
    return (v < MinDim) ? MinDim : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [PixInW-1:0] rand_px();
    return PixInW'($urandom_range(0, 65535));
  endfunction

  function automatic int pick_level();
    int v;
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = 65535;
      default: v = $urandom_range(0, 65535);
    endcase
    return v;
  endfunction

  function automatic logic [PixInW-1:0] next_pixel();
    int v;
    case (px_mode)
      0:       v = $urandom_range(0, 65535);
      1:       v = thr_now + int'($urandom_range(0, 4)) - 2;
      2:       v = $urandom_range(0, 1) ? 65535 : 0;
      default: v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[PixInW-1:0];
  endfunction

  // rows the frame will take, given pixels already fed and the current height
  function automatic int rows_due();
    return (frame_h > fed / frame_w + 1) ? frame_h : fed / frame_w + 1;
  endfunction

  task automatic offer(input op_e op, input logic [PixInW-1:0] px);
    if (!(calm || phase_quiet) && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    pixel_i     <= px;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_frame_regs(input int wv, input int hv, input int tv, input int mv);
    write_reg(RegFrameWidth, wv);
    write_reg(RegFrameHeight, hv);
    write_reg(RegThreshold, tv);
    write_reg(RegMaxValue, mv);
    frame_w = fit(wv, LineLen);
    frame_h = fit(hv, MaxHeight);
    thr_now = tv;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic feed(input int n);
    repeat (n) begin
      if ($urandom_range(0, 29) == 0) offer(OpDrain, rand_px());
      offer(OpPixel, next_pixel());
      fed++;
      items_fed++;
    end
  endtask

  task automatic close_frame();
    int drains;
    drains = (frame_rows > frame_h) ? 1 : frame_w + 1;
    if ($urandom_range(0, 2) == 0) offer(OpPixel, rand_px());
    repeat (drains) begin
      offer(OpDrain, rand_px());
      items_fed++;
    end
    if ($urandom_range(0, 3) == 0) offer(OpDrain, rand_px());
    fed = 0;
  endtask

  initial begin : sink
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        hold_done = 1'b1;
        repeat (LongHold) @(posedge clk_i);
      end else if (!(calm || phase_quiet) && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int rest;
    int hv;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    load_frame_regs(3, 3, 100, 65535);
    offer(OpDrain, '1);
    for (int i = 0; i < 9; i++) offer(OpPixel, SeedFrame[16*i +: 16]);
    offer(OpPixel, 16'h5a5a);
    repeat (4) offer(OpDrain, '0);
    settle();
    write_reg(RegThreshold, 99);
    thr_now = 99;
    for (int i = 0; i < 9; i++) offer(OpPixel, SeedFrame[16*i +: 16]);
    repeat (4) offer(OpDrain, '0);
    settle();

    // output held off for a while to back up the input; clamped tall frame cut short
    hold_req = 1'b1;
    load_frame_regs(6, 2047, pick_level(), pick_level());
    px_mode = 1;
    feed(8 * frame_w);
    settle();
    write_reg(RegFrameHeight, 0);
    frame_h    = fit(0, MaxHeight);
    frame_rows = rows_due();
    feed(frame_rows * frame_w - fed);
    close_frame();

    items_fed = 0;
    while (items_fed < RandomItems || fed != 0) begin
      settle();
      calm        = (items_fed >= QuietFrom);
      phase_quiet = ($urandom_range(0, 4) == 0);
      if (fed == 0) begin
        load_frame_regs($urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 12),
                        $urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 6),
                        pick_level(), pick_level());
        px_mode = $urandom_range(0, 3);
      end else begin
        thr_now = pick_level();
        write_reg(RegThreshold, thr_now);
        write_reg(RegMaxValue, pick_level());
        if ($urandom_range(0, 1) == 0) begin
          hv = $urandom_range(0, 8);
          write_reg(RegFrameHeight, hv);
          frame_h = fit(hv, MaxHeight);
        end
      end
      frame_rows = rows_due();
      rest       = frame_rows * frame_w - fed;
      if (fed == 0 && items_fed < QuietFrom - 100 && $urandom_range(0, 3) == 0) begin
        feed($urandom_range(1, rest - 1));
      end else begin
        feed(rest);
        close_frame();
      end
    end

    settle();
    if (errors == 0) begin
      $display("** median3x3_threshold_filter: PASSED **");
    end else begin
      $display("** median3x3_threshold_filter: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/mtf_pkg.sv
rtl/mtf_queue.sv
rtl/mtf_front.sv
rtl/mtf_back.sv
rtl/median3x3_threshold_filter.sv
bench/mtf_binary_checker.sv
bench/median3x3_threshold_filter_tb.sv
